// ----- src/waveform_tone_generator_core_assert.svh -----
// Assertion macros for the tone generator core.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef WAVEFORM_TONE_GENERATOR_CORE_ASSERT_SVH
`define WAVEFORM_TONE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WTG_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tone generator check failed");

// next-cycle implication, disabled during reset
`define WTG_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tone generator check failed");

`endif

// ----- src/wtg_pkg.sv -----
// Shared types and constants of the tone generator core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wtg_pkg;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_START = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_NOISE    = 2'd3
  } wave_t;

  localparam int FREQ_W = 15;
  localparam int DUR_W  = 24;
  localparam int MAG_W  = 15;

  // one request on the input channel
  typedef struct packed {
    func_t             func;
    logic [FREQ_W-1:0] freq;
    wave_t             wave;
    logic [DUR_W-1:0]  dur;
  } item_t;

  // what the voice hands to the shaper for one tick
  typedef struct packed {
    logic        valid;
    logic        playing;
    wave_t       wave;
    logic [31:0] phase;
    logic [15:0] noise;
  } tone_t;

  // state updates requested by the input stage
  typedef struct packed {
    logic start;
    logic tick;
    logic drain;
  } voice_ctrl_t;

  localparam logic signed [15:0] FULL_SCALE = 16'sd32767;
  localparam logic [15:0]        NOISE_TAPS = 16'hB400;
  localparam logic [15:0]        NOISE_SEED = 16'hACE1;

  // ceil(2^49 / 375): step = (freq * STEP_RECIP) >> STEP_SHIFT = floor(freq * 2^32 / 48000)
  localparam logic [40:0] STEP_RECIP = 41'd1501199875791;
  localparam int          STEP_SHIFT = 24;

  // quarter-wave sine polynomial, Q30
  localparam logic [63:0] SIN_A1 = 64'd1686629713;
  localparam logic [63:0] SIN_A3 = 64'd693598668;
  localparam logic [63:0] SIN_A5 = 64'd85569306;
  localparam logic [63:0] SIN_A7 = 64'd5026995;

  localparam logic [46:0] TRI_ROUND = 47'h0000_2000_0000;

endpackage

// ----- src/waveform_tone_generator_core.sv -----
// Channel  Dir  Ports                          Payload
// in       in   in_tvalid/in_tready/in_tdata   tdata: frequency_hz, waveform, duration_samples
//                         in_tuser             tuser: func
// out      out  out_tvalid/out_tready/out_tdata tdata: sample; tuser: playing
//
// One request per cycle while the output is not stalled; a tick's sample passes the input
// register, the state update with sine table read and the result register after acceptance.
// Start requests update the note state and leave no result.
// Synchronous reset clears state; no clearing pass is needed.
// A stalled output holds the pipeline back stage by stage.
`timescale 1ns / 1ps
`include "waveform_tone_generator_core_assert.svh"

module waveform_tone_generator_core
  import wtg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int DURATION_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [14:0] frequency_hz, [16:15] waveform, [40:17] duration_samples
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample
  output logic [0:0]  out_tuser   // [0] playing
);

  logic        s1_valid_r;
  item_t       s1_item_r;
  item_t       in_item;
  logic        s1_fire;
  logic        s2_free;
  logic        out_free;
  voice_ctrl_t ctrl;
  tone_t       tone;
  logic [31:0] rom_phase;
  logic [MAG_W-1:0] sine_mag;
  logic        out_playing;

  assign in_item.func = func_t'(in_tuser[0]);
  assign in_item.freq = in_tdata[14:0];
  assign in_item.wave = wave_t'(in_tdata[16:15]);
  assign in_item.dur  = in_tdata[40:17];

  assign s2_free   = !tone.valid || out_free;
  assign s1_fire   = s1_valid_r && ((s1_item_r.func == FUNC_START) || s2_free);
  assign in_tready = !s1_valid_r || s1_fire;

  assign ctrl.start = s1_fire && (s1_item_r.func == FUNC_START);
  assign ctrl.tick  = s1_fire && (s1_item_r.func == FUNC_TICK);
  assign ctrl.drain = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
  end

  wtg_voice #(
    .DURATION_BITS(DURATION_BITS)
  ) u_voice (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .item     (s1_item_r),
    .rom_phase(rom_phase),
    .tone     (tone)
  );

  wtg_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk  (clk),
    .rd_en(ctrl.tick),
    .phase(rom_phase),
    .mag  (sine_mag)
  );

  wtg_shaper u_shaper (
    .clk        (clk),
    .rst_n      (rst_n),
    .tone       (tone),
    .sine_mag   (sine_mag),
    .out_ready  (out_tready),
    .out_free   (out_free),
    .out_valid  (out_tvalid),
    .out_sample (out_tdata),
    .out_playing(out_playing)
  );

  assign out_tuser[0] = out_playing;

  `WTG_ASSERT_IMP(a_idle_is_silent, out_tvalid && !out_tuser[0], out_tdata == 16'h0000)
  `WTG_ASSERT_IMP(a_sample_in_range, out_tvalid, out_tdata != 16'h8000)
  `WTG_ASSERT_IMP(a_stall_needs_item, !in_tready, s1_valid_r)
  `WTG_ASSERT_NXT(a_tick_reg_holds, tone.valid && out_tvalid && !out_tready, $stable(tone))

endmodule

// ----- src/wtg_sine_rom.sv -----
// Quarter-wave sine magnitude table with registered read.
// Depends on wtg_pkg for the polynomial coefficients.
`timescale 1ns / 1ps

module wtg_sine_rom
  import wtg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [31:0]      phase,
  output logic [MAG_W-1:0] mag
);

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int IDX_W   = SINE_TABLE_BITS - 1;

  typedef logic [MAG_W-1:0] mag_arr_t [QUARTER+1];

  function automatic mag_arr_t build_table();
    mag_arr_t    tbl;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] m;
    for (int v = 0; v <= QUARTER; v++) begin
      u  = 64'(v) << (18 - SINE_TABLE_BITS);
      u2 = (u * u) >> 16;
      t  = SIN_A7;
      t  = SIN_A5 - ((t * u2) >> 16);
      t  = SIN_A3 - ((t * u2) >> 16);
      t  = SIN_A1 - ((t * u2) >> 16);
      s  = (t * u) >> 16;
      m  = (s * 64'd32767 + 64'h2000_0000) >> 30;
      if (m > 64'd32767) begin
        m = 64'd32767;
      end
      tbl[v] = MAG_W'(m);
    end
    return tbl;
  endfunction

  localparam mag_arr_t SINE_MAG = build_table();

  logic [SINE_TABLE_BITS-1:0] k;
  logic [IDX_W-1:0]           r_ext;
  logic [IDX_W-1:0]           idx;
  logic [MAG_W-1:0]           mag_r;

  assign k     = phase[31 -: SINE_TABLE_BITS];
  assign r_ext = {1'b0, k[SINE_TABLE_BITS-3:0]};
  // mirror the index in the second and fourth quadrant
  assign idx   = k[SINE_TABLE_BITS-2] ? (IDX_W'(QUARTER) - r_ext) : r_ext;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mag_r <= SINE_MAG[idx];
    end
  end

  assign mag = mag_r;

endmodule

// ----- src/wtg_voice.sv -----
// Note state: phase accumulator, remaining count, step, waveform, noise LFSR.
// Depends on wtg_pkg; feeds the sine table address and the tick register.
`timescale 1ns / 1ps

module wtg_voice
  import wtg_pkg::*;
#(
  parameter int DURATION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  voice_ctrl_t ctrl,
  input  item_t       item,
  output logic [31:0] rom_phase,
  output tone_t       tone
);

  logic [31:0]              phase_r, phase_nxt;
  logic [DURATION_BITS-1:0] remaining_r, remaining_nxt;
  logic [31:0]              step_r, step_nxt;
  wave_t                    wave_r, wave_nxt;
  logic [15:0]              noise_r, noise_nxt;
  logic                     tone_valid_r, tone_valid_nxt;
  logic                     tone_playing_r;
  wave_t                    tone_wave_r;
  logic [31:0]              tone_phase_r;
  logic [15:0]              tone_noise_r;

  logic        playing;
  logic [15:0] lfsr_step;
  logic [35:0] prod_hi;
  logic [34:0] prod_lo;
  logic [55:0] step_prod;
  logic [31:0] step_calc;

  assign playing   = (remaining_r != '0);
  assign lfsr_step = {1'b0, noise_r[15:1]} ^ (noise_r[0] ? NOISE_TAPS : 16'h0000);

  assign prod_hi   = item.freq * STEP_RECIP[40:20];
  assign prod_lo   = item.freq * STEP_RECIP[19:0];
  assign step_prod = {prod_hi, 20'b0} + 56'(prod_lo);
  assign step_calc = step_prod[STEP_SHIFT +: 32];

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    step_nxt      = step_r;
    wave_nxt      = wave_r;
    noise_nxt     = noise_r;
    if (ctrl.start) begin
      step_nxt      = step_calc;
      wave_nxt      = item.wave;
      remaining_nxt = DURATION_BITS'(item.dur);
    end else if (ctrl.tick && playing) begin
      remaining_nxt = remaining_r - DURATION_BITS'(1);
      phase_nxt     = phase_r + step_r;
      if (wave_r == WAVE_NOISE) begin
        noise_nxt = lfsr_step;
      end
    end
  end

  always_comb begin
    if (ctrl.tick) begin
      tone_valid_nxt = 1'b1;
    end else if (ctrl.drain) begin
      tone_valid_nxt = 1'b0;
    end else begin
      tone_valid_nxt = tone_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      remaining_r  <= '0;
      step_r       <= '0;
      wave_r       <= WAVE_SINE;
      noise_r      <= NOISE_SEED;
      tone_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      remaining_r  <= remaining_nxt;
      step_r       <= step_nxt;
      wave_r       <= wave_nxt;
      noise_r      <= noise_nxt;
      tone_valid_r <= tone_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tick) begin
      tone_playing_r <= playing;
      tone_wave_r    <= wave_r;
      tone_phase_r   <= phase_nxt;
      tone_noise_r   <= noise_nxt;
    end
  end

  assign rom_phase = phase_nxt;
  assign tone      = {tone_valid_r, tone_playing_r, tone_wave_r, tone_phase_r, tone_noise_r};

endmodule

// ----- src/wtg_shaper.sv -----
// Wave shaping and result register: sine sign, square, triangle, noise.
// Depends on wtg_pkg; takes the tick register and the sine table output.
`timescale 1ns / 1ps

module wtg_shaper
  import wtg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tone_t            tone,
  input  logic [MAG_W-1:0] sine_mag,
  input  logic             out_ready,
  output logic             out_free,
  output logic             out_valid,
  output logic [15:0]      out_sample,
  output logic             out_playing
);

  logic        out_valid_r;
  logic [15:0] sample_r, sample_nxt;
  logic        playing_r;
  logic        load;

  logic signed [15:0] mag_s;
  logic [31:0]        tri_d;
  logic [46:0]        tri_prod;
  logic [16:0]        tri_v;

  assign out_free = !out_valid_r || out_ready;
  assign load     = tone.valid && out_free;

  assign mag_s    = {1'b0, sine_mag};
  assign tri_d    = tone.phase[31] ? {1'b0, tone.phase[30:0]} : (32'h8000_0000 - tone.phase);
  assign tri_prod = {tri_d, 15'b0} - 47'(tri_d) + TRI_ROUND;
  assign tri_v    = tri_prod[46:30];

  always_comb begin
    sample_nxt = '0;
    if (tone.playing) begin
      unique case (tone.wave)
        WAVE_SINE:     sample_nxt = tone.phase[31] ? -mag_s : mag_s;
        WAVE_SQUARE:   sample_nxt = tone.phase[31] ? -FULL_SCALE : FULL_SCALE;
        WAVE_TRIANGLE: sample_nxt = 16'(tri_v - 17'(FULL_SCALE));
        WAVE_NOISE:    sample_nxt = {~tone.noise[15], tone.noise[14:0]};
        default:       sample_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_r  <= sample_nxt;
      playing_r <= tone.playing;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = sample_r;
  assign out_playing = playing_r;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for waveform_tone_generator_core: directed notes, then random
// note/tick sequences with idle bursts on both streams, checked against a local predictor.
// Depends on wtg_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import wtg_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int ITEM_TARGET  = 1100;
  localparam int CALM_TAIL    = 150;

  localparam logic [63:0] POLY_C1 = 64'd1686629713;
  localparam logic [63:0] POLY_C3 = 64'd693598668;
  localparam logic [63:0] POLY_C5 = 64'd85569306;
  localparam logic [63:0] POLY_C7 = 64'd5026995;
  localparam logic [63:0] RATE_HZ = 64'd48000;

  typedef struct {
    logic signed [15:0] sample;
    logic               playing;
  } tone_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  item_t     requests[$];
  tone_out_t samples_due[$];
  item_t     on_bus;
  int        fails = 0;
  int        cycles = 0;

  logic [31:0] voice_phase;
  logic [23:0] voice_left;
  logic [31:0] voice_step;
  wave_t       voice_wave;
  logic [15:0] voice_lfsr;

  int drv_gap = 0, drv_span = 0, mon_gap = 0, mon_span = 0;
  bit drv_busy = 1'b0, mon_busy = 1'b0;

  waveform_tone_generator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [15:0] sine_at(input logic [31:0] p);
    logic [9:0]         k;
    logic [1:0]         q;
    logic [63:0]        u, u2, t, s, mag;
    logic signed [15:0] m;
    k = p[31:22];
    q = k[9:8];
    u = {48'd0, k[7:0], 8'd0};
    if (q[0]) u = 64'd65536 - u;
    u2 = (u * u) >> 16;
    t = POLY_C7;
    t = POLY_C5 - ((t * u2) >> 16);
    t = POLY_C3 - ((t * u2) >> 16);
    t = POLY_C1 - ((t * u2) >> 16);
    s = (t * u) >> 16;
    mag = (s * 64'd32767 + 64'd536870912) >> 30;
    if (mag > 64'd32767) mag = 64'd32767;
    m = mag[15:0];
    return q[1] ? -m : m;
  endfunction

  function automatic logic signed [15:0] triangle_at(input logic [31:0] p);
    logic [63:0] d, v;
    d = (p >= 32'h8000_0000) ? {32'd0, p - 32'h8000_0000} : {32'd0, 32'h8000_0000 - p};
    v = (d * 64'd32767 + 64'd536870912) >> 30;
    return v[15:0] - 16'd32767;
  endfunction

  // advance the voice by one request; push the sample a tick produces
  function automatic void play_request(input item_t r);
    tone_out_t   o;
    logic [63:0] f;
    if (r.func == FUNC_START) begin
      f = {49'd0, r.freq};
      voice_step = 32'((f << 32) / RATE_HZ);
      voice_wave = r.wave;
      voice_left = r.dur;
    end else begin
      o.sample = '0;
      o.playing = 1'b0;
      if (voice_left != '0) begin
        voice_left = voice_left - 1'b1;
        voice_phase = voice_phase + voice_step;
        o.playing = 1'b1;
        case (voice_wave)
          WAVE_SINE:     o.sample = sine_at(voice_phase);
          WAVE_SQUARE:   o.sample = voice_phase[31] ? -16'sd32767 : 16'sd32767;
          WAVE_TRIANGLE: o.sample = triangle_at(voice_phase);
          default: begin
            voice_lfsr = {1'b0, voice_lfsr[15:1]} ^ (voice_lfsr[0] ? 16'hB400 : 16'h0000);
            o.sample = voice_lfsr ^ 16'h8000;
          end
        endcase
      end
      samples_due.push_back(o);
    end
  endfunction

  function automatic item_t scatter();
    item_t r;
    r.func = FUNC_TICK;
    r.freq = 15'($urandom_range(0, 32767));
    r.wave = wave_t'($urandom_range(0, 3));
    r.dur  = 24'($urandom);
    return r;
  endfunction

  function automatic void add_ticks(input int n);
    repeat (n) requests.push_back(scatter());
  endfunction

  function automatic void add_note(input logic [14:0] freq, input wave_t wave,
                                   input logic [23:0] dur);
    item_t r;
    r = scatter();
    r.func = FUNC_START;
    r.freq = freq;
    r.wave = wave;
    r.dur  = dur;
    requests.push_back(r);
  endfunction

  // driver: present queued requests, idle in short bursts between them
  always @(posedge clk) begin
    bit nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) play_request(on_bus);
      if (!in_tvalid || in_tready) begin
        if (drv_span == 0) begin
          drv_span = $urandom_range(20, 80);
          drv_busy = ($urandom_range(0, 2) != 0);
        end else begin
          drv_span--;
        end
        nxt = 1'b0;
        if (drv_gap != 0) begin
          drv_gap--;
        end else if (requests.size() == 0) begin
          nxt = 1'b0;
        end else if (drv_busy && requests.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
          drv_gap = $urandom_range(0, 3);
        end else begin
          on_bus = requests.pop_front();
          in_tdata <= {7'd0, on_bus.dur, on_bus.wave, on_bus.freq};
          in_tuser <= on_bus.func;
          nxt = 1'b1;
        end
        in_tvalid <= nxt;
      end
    end
  end

  // monitor: compare each result with the oldest expected sample, stall in bursts
  always @(posedge clk) begin
    tone_out_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (samples_due.size() == 0) begin
          $error("unexpected result: sample %0d playing %0b", $signed(out_tdata), out_tuser[0]);
          fails++;
        end else begin
          w = samples_due.pop_front();
          if (out_tdata !== w.sample) begin
            $error("sample: expected %0d, got %0d", w.sample, $signed(out_tdata));
            fails++;
          end
          if (out_tuser[0] !== w.playing) begin
            $error("playing: expected %0b, got %0b", w.playing, out_tuser[0]);
            fails++;
          end
        end
      end
      if (mon_span == 0) begin
        mon_span = $urandom_range(20, 80);
        mon_busy = ($urandom_range(0, 2) != 0);
      end else begin
        mon_span--;
      end
      if (mon_gap != 0) begin
        mon_gap--;
        out_tready <= 1'b0;
      end else if (mon_busy && requests.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
        mon_gap = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [23:0] dur;
    logic [14:0] freq;
    int          sel;
    item_t       r;
    voice_phase = '0;
    voice_left  = '0;
    voice_step  = '0;
    voice_wave  = WAVE_SINE;
    voice_lfsr  = 16'hACE1;

    // idle tick, note replaced mid-play, every wave, alias, zero and long durations
    add_ticks(1);
    add_note(15'd1000, WAVE_SINE, 24'd3);
    add_ticks(2);
    add_note(15'd24000, WAVE_SQUARE, 24'd2);
    add_ticks(3);
    add_note(15'd32767, WAVE_TRIANGLE, 24'd2);
    add_ticks(2);
    add_note(15'd12345, WAVE_NOISE, 24'd3);
    add_ticks(2);
    add_note(15'd0, WAVE_NOISE, 24'd0);
    add_ticks(1);
    add_note(15'd0, WAVE_SINE, 24'hFF_FFFF);
    add_ticks(1);
    add_note(15'd1, WAVE_TRIANGLE, 24'd1);
    add_ticks(1);

    while (requests.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        r = scatter();
        r.func = func_t'($urandom_range(0, 1));
        requests.push_back(r);
      end else begin
        sel = $urandom_range(0, 9);
        dur = (sel == 0) ? 24'd0 : (sel == 1) ? 24'($urandom) : 24'($urandom_range(1, 30));
        freq = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(0, 32767))
                                           : 15'($urandom_range(20, 24000));
        add_note(freq, wave_t'($urandom_range(0, 3)), dur);
        add_ticks($urandom_range(0, ((dur > 24'd30) ? 30 : int'(dur)) + 3));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (requests.size() != 0 || in_tvalid) @(posedge clk);
    while (samples_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/wtg_pkg.sv
src/wtg_sine_rom.sv
src/wtg_voice.sv
src/wtg_shaper.sv
src/waveform_tone_generator_core.sv
tb/sv/tb.sv
